### design/gdda_pkg.sv
`timescale 1ns / 1ps
package gdda_pkg;

	// map and walk limits
	localparam int MAP_DIM   = 64;
	localparam int MAX_STEPS = 128;
	localparam int COORD_W   = 6;
	localparam int MAP_AW    = 2 * COORD_W;
	localparam int MAP_DEPTH = MAP_DIM * MAP_DIM;
	localparam int WALK_W    = COORD_W + 2;
	localparam int STEP_W    = $clog2(MAX_STEPS + 1);

	// fixed point widths
	localparam int POS_W   = 22;
	localparam int DIR_W   = 16;
	localparam int FRAC_W  = 16;
	localparam int SW_W    = 13;
	localparam int COL_W   = 12;
	localparam int RD_W    = 30;
	localparam int DIST_W  = 32;
	localparam int ODIST_W = 24;
	localparam int KIND_W  = 2;

	// shared units
	localparam int DIV_W  = 32;
	localparam int MUL_AW = 32;
	localparam int MUL_BW = 16;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	localparam logic [DIST_W-1:0]  DIST_INF   = '1;
	localparam logic [ODIST_W-1:0] ODIST_MAX  = '1;
	localparam logic [DIV_W-1:0]   RECIP_NUM  = DIV_W'(64'd1 << 30);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_ROW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_COL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_ROW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR_COL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_ROW = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W  = 3'd6;

	// codes
	localparam logic FUNC_CAST  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WALL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DOOR  = 2'd2;

	typedef struct packed {
		logic                func;
		logic [COL_W-1:0]    column;
		logic [COORD_W-1:0]  cell_row;
		logic [COORD_W-1:0]  cell_col;
		logic [KIND_W-1:0]   cell_kind;
		logic [FRAC_W-1:0]   door_open;
	} cmd_t;

	typedef struct packed {
		logic [COL_W-1:0]    out_column;
		logic [ODIST_W-1:0]  wall_distance;
		logic [KIND_W-1:0]   hit_kind;
		logic                hit_side;
		logic [COORD_W-1:0]  hit_row;
		logic [COORD_W-1:0]  hit_col;
	} res_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

endpackage

### design/grid_ray_caster_dda_top.sv
`timescale 1ns / 1ps
// Cast word: ray setup (up to four divisions on the shared divider), then a step and a map
// check per grid cell stepped, a crossing test per door cell, and the move into the output.
// Write word: taken while the block is idle, no result. One word is worked on at a time.
// Reset: asynchronous, active low; config returns to its defaults, then a clearing
// pass empties the map while cmd_stall stays high.
module grid_ray_caster_dda_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  gdda_pkg::cmd_t                    cmd,
	output logic                              res_valid,
	input  logic                              res_stall,
	output gdda_pkg::res_t                    res,
	input  logic                              cfg_we,
	input  logic [gdda_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gdda_pkg::CFG_DATA_W-1:0]   cfg_data
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE,
		S_MULR, S_DIVR_GO, S_DIVR_W, S_MULC, S_DIVC_GO, S_DIVC_W,
		S_RECR, S_RECR_W, S_RECC, S_RECC_W,
		S_FDR, S_FDC, S_FDW,
		S_STEP, S_CHECK, S_DLO, S_DHI, S_DACC, S_DAT, S_DHIT,
		S_DONE
	} state_t;

	// configuration registers
	logic [gdda_pkg::POS_W-1:0]        pos_row_q, pos_col_q;
	logic [gdda_pkg::DIR_W-1:0]        dir_row_q, dir_col_q, plane_row_q, plane_col_q;
	logic [gdda_pkg::SW_W-1:0]         screen_width_q;

	// sequencer state
	state_t                            state_q;
	logic [gdda_pkg::MAP_AW-1:0]       clr_q;
	logic [gdda_pkg::COL_W-1:0]        column_q;
	logic [gdda_pkg::RD_W-1:0]         rdr_q, rdc_q;
	logic [gdda_pkg::DIST_W-1:0]       dr_q, dc_q, sdr_q, sdc_q, ds_q;
	logic [gdda_pkg::COORD_W-1:0]      walk_row_q, walk_col_q;
	logic                              side_q;
	logic [gdda_pkg::STEP_W-1:0]       steps_q;
	logic [gdda_pkg::FRAC_W-1:0]       open_q;
	logic [gdda_pkg::MUL_PW-1:0]       lo_q;
	logic [63:0]                       mag_q;
	logic [49:0]                       at_q;
	gdda_pkg::res_t                    pend_q, out_q;
	logic                              res_valid_q;

	// shared units
	gdda_pkg::div_req_t                div_req;
	logic                              div_busy, div_done;
	logic [gdda_pkg::DIV_W-1:0]        div_quo;
	logic [gdda_pkg::MUL_AW-1:0]       mul_a;
	logic [gdda_pkg::MUL_BW-1:0]       mul_b;
	logic [gdda_pkg::MUL_PW-1:0]       mul_p;

	// map stores
	logic                              kind_we, door_we;
	logic [gdda_pkg::MAP_AW-1:0]       kind_waddr, map_raddr;
	logic [gdda_pkg::KIND_W-1:0]       kind_wdata, kind_rd;
	logic [gdda_pkg::FRAC_W-1:0]       door_rd;

	logic                              cmd_take;

	// camera x terms
	logic [gdda_pkg::SW_W-1:0]         den;
	logic [14:0]                       k_raw;
	logic                              k_neg;
	logic [13:0]                       k_mag;
	logic [gdda_pkg::DIR_W-1:0]        pl_sel, pl_mag, dir_sel;
	logic                              q_neg;
	logic [gdda_pkg::RD_W-1:0]         q_mag, q_s, rd_new;
	logic [gdda_pkg::RD_W-1:0]         rdm_row, rdm_col;

	// first boundary distances
	logic [16:0]                       fr_row, fr_col;
	logic [gdda_pkg::DIST_W-1:0]       first_row, first_col;

	// walk step
	logic                              go_row;
	logic [32:0]                       sum_row, sum_col;
	logic [gdda_pkg::DIST_W-1:0]       sat_row, sat_col;
	logic [gdda_pkg::WALK_W-1:0]       wr_nxt, wc_nxt;
	logic                              leave;

	// hit tests
	logic [gdda_pkg::DIST_W-1:0]       sd_sel, d_sel, half, s_wall, s_door;
	logic [gdda_pkg::ODIST_W-1:0]      wall_sat, door_sat;
	logic [gdda_pkg::RD_W-1:0]         drd;
	logic [gdda_pkg::RD_W-1:0]         drd_mag;
	logic [gdda_pkg::POS_W-1:0]        dpos;
	logic [gdda_pkg::COORD_W-1:0]      dwalk;
	logic [63:0]                       qm_full;
	logic [49:0]                       qm, at_nxt, lim_lo, lim_hi;
	logic                              door_hit;

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;

	// configuration writes land whenever offered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_row_q      <= 22'd65536;
			pos_col_q      <= 22'd65536;
			dir_row_q      <= 16'd16384;
			dir_col_q      <= 16'd0;
			plane_row_q    <= 16'd0;
			plane_col_q    <= 16'd10813;
			screen_width_q <= 13'd640;
		end else if (cfg_we) begin
			case (cfg_index)
				gdda_pkg::CFG_POS_ROW:   pos_row_q      <= cfg_data[gdda_pkg::POS_W-1:0];
				gdda_pkg::CFG_POS_COL:   pos_col_q      <= cfg_data[gdda_pkg::POS_W-1:0];
				gdda_pkg::CFG_DIR_ROW:   dir_row_q      <= cfg_data[gdda_pkg::DIR_W-1:0];
				gdda_pkg::CFG_DIR_COL:   dir_col_q      <= cfg_data[gdda_pkg::DIR_W-1:0];
				gdda_pkg::CFG_PLANE_ROW: plane_row_q    <= cfg_data[gdda_pkg::DIR_W-1:0];
				gdda_pkg::CFG_PLANE_COL: plane_col_q    <= cfg_data[gdda_pkg::DIR_W-1:0];
				gdda_pkg::CFG_SCREEN_W:  screen_width_q <= cfg_data[gdda_pkg::SW_W-1:0];
				default: ;
			endcase
		end
	end

	// Map stores: kind is swept to empty after reset, door fractions are never cleared.
	// A kind of three is stored as empty.
	always_comb begin
		kind_we    = (state_q == S_CLEAR) || (cmd_take && cmd.func == gdda_pkg::FUNC_WRITE);
		door_we    = cmd_take && cmd.func == gdda_pkg::FUNC_WRITE;
		kind_waddr = (state_q == S_CLEAR) ? clr_q : {cmd.cell_row, cmd.cell_col};
		if (state_q == S_CLEAR) begin
			kind_wdata = gdda_pkg::KIND_EMPTY;
		end else if (cmd.cell_kind == gdda_pkg::KIND_WALL
				|| cmd.cell_kind == gdda_pkg::KIND_DOOR) begin
			kind_wdata = cmd.cell_kind;
		end else begin
			kind_wdata = gdda_pkg::KIND_EMPTY;
		end
	end

	gdda_ram #(.WIDTH(gdda_pkg::KIND_W), .DEPTH(gdda_pkg::MAP_DEPTH)) u_kind_ram (
		.clk   (clk),
		.we    (kind_we),
		.waddr (kind_waddr),
		.wdata (kind_wdata),
		.raddr (map_raddr),
		.rdata (kind_rd)
	);

	gdda_ram #(.WIDTH(gdda_pkg::FRAC_W), .DEPTH(gdda_pkg::MAP_DEPTH)) u_door_ram (
		.clk   (clk),
		.we    (door_we),
		.waddr ({cmd.cell_row, cmd.cell_col}),
		.wdata (cmd.door_open),
		.raddr (map_raddr),
		.rdata (door_rd)
	);

	gdda_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	gdda_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// Ray build: rd = dir + trunc(plane * k / den), k = 2*column - den.
	always_comb begin
		den     = ((screen_width_q < 13'd2) ? 13'd2 : screen_width_q) - 13'd1;
		k_raw   = {2'b00, column_q, 1'b0} - {2'b00, den};
		k_neg   = k_raw[14];
		k_mag   = k_neg ? 14'(~k_raw + 15'd1) : k_raw[13:0];
		if (state_q == S_MULR || state_q == S_DIVR_GO || state_q == S_DIVR_W) begin
			pl_sel  = plane_row_q;
			dir_sel = dir_row_q;
		end else begin
			pl_sel  = plane_col_q;
			dir_sel = dir_col_q;
		end
		pl_mag  = pl_sel[gdda_pkg::DIR_W-1] ? (~pl_sel + 16'd1) : pl_sel;
		q_neg   = pl_sel[gdda_pkg::DIR_W-1] ^ k_neg;
		q_mag   = div_quo[gdda_pkg::RD_W-1:0];
		q_s     = q_neg ? (~q_mag + 30'd1) : q_mag;
		rd_new  = {{(gdda_pkg::RD_W-gdda_pkg::DIR_W){dir_sel[gdda_pkg::DIR_W-1]}}, dir_sel}
			+ q_s;
		rdm_row = rdr_q[gdda_pkg::RD_W-1] ? (~rdr_q + 30'd1) : rdr_q;
		rdm_col = rdc_q[gdda_pkg::RD_W-1] ? (~rdc_q + 30'd1) : rdc_q;
	end

	// Cell fraction to the first boundary; a full cell gives the step length itself.
	always_comb begin
		fr_row = rdr_q[gdda_pkg::RD_W-1] ? {1'b0, pos_row_q[15:0]}
			: (17'h10000 - {1'b0, pos_row_q[15:0]});
		fr_col = rdc_q[gdda_pkg::RD_W-1] ? {1'b0, pos_col_q[15:0]}
			: (17'h10000 - {1'b0, pos_col_q[15:0]});
		if (dr_q == gdda_pkg::DIST_INF) begin
			first_row = gdda_pkg::DIST_INF;
		end else if (fr_row[16]) begin
			first_row = dr_q;
		end else begin
			first_row = mul_p[47:16];
		end
		if (dc_q == gdda_pkg::DIST_INF) begin
			first_col = gdda_pkg::DIST_INF;
		end else if (fr_col[16]) begin
			first_col = dc_q;
		end else begin
			first_col = mul_p[47:16];
		end
	end

	// Walk step: the nearer boundary wins, a tie steps the column.
	always_comb begin
		go_row   = sdr_q < sdc_q;
		sum_row  = {1'b0, sdr_q} + {1'b0, dr_q};
		sum_col  = {1'b0, sdc_q} + {1'b0, dc_q};
		sat_row  = sum_row[32] ? gdda_pkg::DIST_INF : sum_row[31:0];
		sat_col  = sum_col[32] ? gdda_pkg::DIST_INF : sum_col[31:0];
		wr_nxt   = {2'b00, walk_row_q};
		wc_nxt   = {2'b00, walk_col_q};
		if (go_row) begin
			wr_nxt = rdr_q[gdda_pkg::RD_W-1] ? (wr_nxt - 8'd1) : (wr_nxt + 8'd1);
		end else begin
			wc_nxt = rdc_q[gdda_pkg::RD_W-1] ? (wc_nxt - 8'd1) : (wc_nxt + 8'd1);
		end
		leave = ($signed(wr_nxt) < 8'sd0) || ($signed(wr_nxt) >= $signed(8'(gdda_pkg::MAP_DIM)))
			|| ($signed(wc_nxt) < 8'sd0) || ($signed(wc_nxt) >= $signed(8'(gdda_pkg::MAP_DIM)));
		// read address follows the cell being entered
		map_raddr = {wr_nxt[gdda_pkg::COORD_W-1:0], wc_nxt[gdda_pkg::COORD_W-1:0]};
	end

	// Hit distances and the door crossing test.
	always_comb begin
		sd_sel    = side_q ? sdc_q : sdr_q;
		d_sel     = side_q ? dc_q : dr_q;
		half      = d_sel >> 1;
		s_wall    = (sd_sel >= d_sel) ? (sd_sel - d_sel) : '0;
		s_door    = (sd_sel >= half) ? (sd_sel - half) : '0;
		wall_sat  = (|s_wall[31:24]) ? gdda_pkg::ODIST_MAX : s_wall[23:0];
		door_sat  = (|ds_q[31:24]) ? gdda_pkg::ODIST_MAX : ds_q[23:0];
		drd       = side_q ? rdr_q : rdc_q;
		drd_mag   = side_q ? rdm_row : rdm_col;
		dpos      = side_q ? pos_row_q : pos_col_q;
		dwalk     = side_q ? walk_row_q : walk_col_q;
		// floor of the signed product over 2^14
		qm_full   = drd[gdda_pkg::RD_W-1] ? ((mag_q + 64'd16383) >> 14) : (mag_q >> 14);
		qm        = qm_full[49:0];
		at_nxt    = {28'd0, dpos} + (drd[gdda_pkg::RD_W-1] ? (~qm + 50'd1) : qm);
		lim_lo    = {28'd0, dwalk, open_q};
		lim_hi    = {27'd0, ({1'b0, dwalk} + 7'd1), 16'd0};
		door_hit  = ($signed(at_q) > $signed(lim_lo)) && ($signed(at_q) < $signed(lim_hi));
	end

	// shared unit operands by sequencer step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_req.start    = 1'b0;
		div_req.dividend = mul_p[gdda_pkg::DIV_W-1:0];
		div_req.divisor  = {{(gdda_pkg::DIV_W-gdda_pkg::SW_W){1'b0}}, den};
		case (state_q)
			S_MULR, S_MULC: begin
				mul_a = {18'd0, k_mag};
				mul_b = pl_mag;
			end
			S_DIVR_GO, S_DIVC_GO: begin
				div_req.start = 1'b1;
			end
			S_RECR: begin
				div_req.start    = (rdr_q != '0);
				div_req.dividend = gdda_pkg::RECIP_NUM;
				div_req.divisor  = {2'b00, rdm_row};
			end
			S_RECC: begin
				div_req.start    = (rdc_q != '0);
				div_req.dividend = gdda_pkg::RECIP_NUM;
				div_req.divisor  = {2'b00, rdm_col};
			end
			S_FDR: begin
				mul_a = dr_q;
				mul_b = fr_row[15:0];
			end
			S_FDC: begin
				mul_a = dc_q;
				mul_b = fr_col[15:0];
			end
			S_DLO: begin
				mul_a = ds_q;
				mul_b = drd_mag[15:0];
			end
			S_DHI: begin
				mul_a = ds_q;
				mul_b = {2'b00, drd_mag[gdda_pkg::RD_W-1:16]};
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			steps_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// drop the output word once taken, unless a new one loads now
			if (res_valid_q && !res_stall && state_q != S_DONE) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + gdda_pkg::MAP_AW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_take && cmd.func == gdda_pkg::FUNC_CAST) begin
						column_q <= cmd.column;
						state_q  <= S_MULR;
					end
				end
				S_MULR:    state_q <= S_DIVR_GO;
				S_DIVR_GO: state_q <= S_DIVR_W;
				S_DIVR_W: begin
					if (div_done) begin
						rdr_q   <= rd_new;
						state_q <= S_MULC;
					end
				end
				S_MULC:    state_q <= S_DIVC_GO;
				S_DIVC_GO: state_q <= S_DIVC_W;
				S_DIVC_W: begin
					if (div_done) begin
						rdc_q   <= rd_new;
						state_q <= S_RECR;
					end
				end
				S_RECR: begin
					// a zero component never reaches its boundary
					if (rdr_q == '0) begin
						dr_q    <= gdda_pkg::DIST_INF;
						state_q <= S_RECC;
					end else begin
						state_q <= S_RECR_W;
					end
				end
				S_RECR_W: begin
					if (div_done) begin
						dr_q    <= div_quo;
						state_q <= S_RECC;
					end
				end
				S_RECC: begin
					if (rdc_q == '0) begin
						dc_q    <= gdda_pkg::DIST_INF;
						state_q <= S_FDR;
					end else begin
						state_q <= S_RECC_W;
					end
				end
				S_RECC_W: begin
					if (div_done) begin
						dc_q    <= div_quo;
						state_q <= S_FDR;
					end
				end
				S_FDR: state_q <= S_FDC;
				S_FDC: begin
					sdr_q   <= first_row;
					state_q <= S_FDW;
				end
				S_FDW: begin
					sdc_q      <= first_col;
					walk_row_q <= pos_row_q[gdda_pkg::POS_W-1:gdda_pkg::FRAC_W];
					walk_col_q <= pos_col_q[gdda_pkg::POS_W-1:gdda_pkg::FRAC_W];
					steps_q    <= '0;
					state_q    <= S_STEP;
				end
				S_STEP: begin
					if (steps_q == gdda_pkg::STEP_W'(gdda_pkg::MAX_STEPS)) begin
						pend_q.out_column    <= column_q;
						pend_q.wall_distance <= gdda_pkg::ODIST_MAX;
						pend_q.hit_kind      <= gdda_pkg::KIND_NONE;
						pend_q.hit_side      <= 1'b0;
						pend_q.hit_row       <= '0;
						pend_q.hit_col       <= '0;
						state_q              <= S_DONE;
					end else begin
						steps_q <= steps_q + gdda_pkg::STEP_W'(1);
						side_q  <= !go_row;
						if (go_row) begin
							sdr_q <= sat_row;
						end else begin
							sdc_q <= sat_col;
						end
						walk_row_q <= wr_nxt[gdda_pkg::COORD_W-1:0];
						walk_col_q <= wc_nxt[gdda_pkg::COORD_W-1:0];
						if (leave) begin
							pend_q.out_column    <= column_q;
							pend_q.wall_distance <= gdda_pkg::ODIST_MAX;
							pend_q.hit_kind      <= gdda_pkg::KIND_NONE;
							pend_q.hit_side      <= 1'b0;
							pend_q.hit_row       <= '0;
							pend_q.hit_col       <= '0;
							state_q              <= S_DONE;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (kind_rd == gdda_pkg::KIND_WALL) begin
						pend_q.out_column    <= column_q;
						pend_q.wall_distance <= wall_sat;
						pend_q.hit_kind      <= gdda_pkg::KIND_WALL;
						pend_q.hit_side      <= side_q;
						pend_q.hit_row       <= walk_row_q;
						pend_q.hit_col       <= walk_col_q;
						state_q              <= S_DONE;
					end else if (kind_rd == gdda_pkg::KIND_DOOR) begin
						ds_q    <= s_door;
						open_q  <= door_rd;
						state_q <= S_DLO;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_DLO: state_q <= S_DHI;
				S_DHI: begin
					lo_q    <= mul_p;
					state_q <= S_DACC;
				end
				S_DACC: begin
					mag_q   <= {16'd0, lo_q} + {mul_p, 16'd0};
					state_q <= S_DAT;
				end
				S_DAT: begin
					at_q    <= at_nxt;
					state_q <= S_DHIT;
				end
				S_DHIT: begin
					if (door_hit) begin
						pend_q.out_column    <= column_q;
						pend_q.wall_distance <= door_sat;
						pend_q.hit_kind      <= gdda_pkg::KIND_DOOR;
						pend_q.hit_side      <= side_q;
						pend_q.hit_row       <= walk_row_q;
						pend_q.hit_col       <= walk_col_q;
						state_q              <= S_DONE;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_DONE: begin
					// hold until the output register frees up
					if (!res_valid_q || !res_stall) begin
						out_q       <= pend_q;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = out_q;

	a_nohit_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.hit_kind == gdda_pkg::KIND_NONE |->
		res.wall_distance == gdda_pkg::ODIST_MAX && res.hit_row == '0
		&& res.hit_col == '0 && !res.hit_side)
		else $error("no-hit word carries stray fields");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.hit_kind == gdda_pkg::KIND_NONE
		|| res.hit_kind == gdda_pkg::KIND_WALL || res.hit_kind == gdda_pkg::KIND_DOOR)
		else $error("bad hit kind");

	a_step_limit: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= gdda_pkg::STEP_W'(gdda_pkg::MAX_STEPS))
		else $error("step counter past limit");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_busy)
		else $error("divider restarted while busy");

endmodule

### design/gdda_ram.sv
`timescale 1ns / 1ps
module gdda_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/gdda_div.sv
`timescale 1ns / 1ps
module gdda_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gdda_pkg::div_req_t       req,
	output logic                     busy,
	output logic                     done,
	output logic [gdda_pkg::DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(gdda_pkg::DIV_W);

	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [gdda_pkg::DIV_W-1:0]  rem_q;
	logic [gdda_pkg::DIV_W-1:0]  dvd_q;
	logic [gdda_pkg::DIV_W-1:0]  dsr_q;
	logic [gdda_pkg::DIV_W:0]    trial;
	logic [gdda_pkg::DIV_W+1:0]  diff;
	logic                        ge;

	// one quotient bit a cycle, restoring
	always_comb begin
		trial = {rem_q, dvd_q[gdda_pkg::DIV_W-1]};
		diff  = {1'b0, trial} - {2'b00, dsr_q};
		ge    = !diff[gdda_pkg::DIV_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				dvd_q  <= req.dividend;
				dsr_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= ge ? diff[gdda_pkg::DIV_W-1:0] : trial[gdda_pkg::DIV_W-1:0];
				dvd_q <= {dvd_q[gdda_pkg::DIV_W-2:0], ge};
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(gdda_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

### design/gdda_mul.sv
`timescale 1ns / 1ps
module gdda_mul (
	input  logic                        clk,
	input  logic [gdda_pkg::MUL_AW-1:0] a,
	input  logic [gdda_pkg::MUL_BW-1:0] b,
	output logic [gdda_pkg::MUL_PW-1:0] p
);

	logic [gdda_pkg::MUL_PW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= {{gdda_pkg::MUL_BW{1'b0}}, a} * {{gdda_pkg::MUL_AW{1'b0}}, b};
	end

	assign p = p_q;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import gdda_pkg::*;

	// cell kind that the block folds into empty on a write
	localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
	localparam logic [23:0] FAR_DIST = '1;

	// Scoreboard: keeps its own copy of the map and the camera registers, traces each
	// accepted cast word and queues the expected hit for comparison.
	class ray_scoreboard;
		logic [POS_W-1:0] pos_r, pos_c;
		longint dir_r, dir_c, pl_r, pl_c;
		int unsigned scr_w;
		logic [KIND_W-1:0] kind_map [MAP_DEPTH];
		logic [FRAC_W-1:0] open_map [MAP_DEPTH];
		res_t hits_due [$];
		int errors;

		function new();
			pos_r = 22'h10000; pos_c = 22'h10000;
			dir_r = 16384; dir_c = 0; pl_r = 0; pl_c = 10813;
			scr_w = 640;
			errors = 0;
			foreach (kind_map[i]) begin
				kind_map[i] = KIND_EMPTY;
				open_map[i] = '0;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				CFG_POS_ROW:   pos_r = v;
				CFG_POS_COL:   pos_c = v;
				CFG_DIR_ROW:   dir_r = $signed(v[15:0]);
				CFG_DIR_COL:   dir_c = $signed(v[15:0]);
				CFG_PLANE_ROW: pl_r = $signed(v[15:0]);
				CFG_PLANE_COL: pl_c = $signed(v[15:0]);
				CFG_SCREEN_W:  scr_w = v[SW_W-1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned recip(longint rd);
			longint unsigned m;
			if (rd == 0)
				return 64'hFFFF_FFFF;
			m = rd < 0 ? -rd : rd;
			return ((64'd1 << 30) / m) & 64'hFFFF_FFFF;
		endfunction

		function longint unsigned first_edge(logic [POS_W-1:0] p, longint rd,
			longint unsigned delta);
			longint unsigned fr;
			fr = p[15:0];
			if (delta == 64'hFFFF_FFFF)
				return delta;
			if (rd >= 0)
				fr = 65536 - fr;
			return ((fr * delta) >> 16) & 64'hFFFF_FFFF;
		endfunction

		function longint unsigned sat_add(longint unsigned a, longint unsigned b);
			longint unsigned s;
			s = a + b;
			return s > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : s;
		endfunction

		// ray meets the mid-cell plane past the open part of the door
		function bit door_blocks(longint unsigned sd, longint unsigned delta,
			logic [POS_W-1:0] p, longint rd, int cell_idx, logic [FRAC_W-1:0] open);
			longint unsigned hf, ds;
			longint prod, q, at, lo, hi;
			hf = delta >> 1;
			ds = sd >= hf ? sd - hf : 0;
			prod = longint'(ds) * rd;
			if (prod >= 0)
				q = prod >>> 14;
			else
				q = -((-prod + 16383) >>> 14);
			at = longint'(p) + q;
			lo = longint'(cell_idx) * 65536 + open;
			hi = (longint'(cell_idx) + 1) * 65536;
			return at > lo && at < hi;
		endfunction

		function res_t trace(logic [COL_W-1:0] col);
			longint den, k, rdr, rdc;
			longint unsigned dr, dc, sr, sc, s;
			int wr, wc, side, idx;
			logic [KIND_W-1:0] kind, ck;
			logic [23:0] hit_len;
			res_t r;
			den = (scr_w < 2 ? 2 : scr_w) - 1;
			k = 2 * longint'(col) - den;
			rdr = dir_r + (pl_r * k) / den;
			rdc = dir_c + (pl_c * k) / den;
			dr = recip(rdr);
			dc = recip(rdc);
			sr = first_edge(pos_r, rdr, dr);
			sc = first_edge(pos_c, rdc, dc);
			wr = pos_r >> 16;
			wc = pos_c >> 16;
			kind = KIND_NONE;
			side = 0;
			hit_len = FAR_DIST;
			for (int n = 0; n < MAX_STEPS; n++) begin
				// tie steps the column
				if (sr < sc) begin
					sr = sat_add(sr, dr);
					wr += rdr < 0 ? -1 : 1;
					side = 0;
				end else begin
					sc = sat_add(sc, dc);
					wc += rdc < 0 ? -1 : 1;
					side = 1;
				end
				if (wr < 0 || wr >= MAP_DIM || wc < 0 || wc >= MAP_DIM)
					break;
				idx = wr * MAP_DIM + wc;
				ck = kind_map[idx];
				if (ck == KIND_WALL) begin
					s = side ? sc : sr;
					s = s >= (side ? dc : dr) ? s - (side ? dc : dr) : 0;
					hit_len = s > 64'hFF_FFFF ? FAR_DIST : s[23:0];
					kind = KIND_WALL;
					break;
				end
				if (ck == KIND_DOOR && (side == 0
						? door_blocks(sr, dr, pos_c, rdc, wc, open_map[idx])
						: door_blocks(sc, dc, pos_r, rdr, wr, open_map[idx]))) begin
					s = side ? sc : sr;
					s = s >= ((side ? dc : dr) >> 1) ? s - ((side ? dc : dr) >> 1) : 0;
					hit_len = s > 64'hFF_FFFF ? FAR_DIST : s[23:0];
					kind = KIND_DOOR;
					break;
				end
			end
			r.out_column = col;
			r.hit_kind = kind;
			if (kind != KIND_NONE) begin
				r.wall_distance = hit_len;
				r.hit_side = side[0];
				r.hit_row = wr[5:0];
				r.hit_col = wc[5:0];
			end else begin
				r.wall_distance = FAR_DIST;
				r.hit_side = 1'b0;
				r.hit_row = '0;
				r.hit_col = '0;
			end
			return r;
		endfunction

		function void note_word(cmd_t w);
			if (w.func == FUNC_WRITE) begin
				kind_map[{w.cell_row, w.cell_col}] =
					w.cell_kind == KIND_RESERVED ? KIND_EMPTY : w.cell_kind;
				open_map[{w.cell_row, w.cell_col}] = w.door_open;
			end else begin
				hits_due.push_back(trace(w.column));
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (hits_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: col %0d dist %h kind %0d",
						got.out_column, got.wall_distance, got.hit_kind);
				return;
			end
			want = hits_due.pop_front();
			if (got.out_column !== want.out_column ||
					got.wall_distance !== want.wall_distance ||
					got.hit_kind !== want.hit_kind || got.hit_side !== want.hit_side ||
					got.hit_row !== want.hit_row || got.hit_col !== want.hit_col) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp col %0d dist %h kind %0d side %0d cell %0d,%0d | got col %0d dist %h kind %0d side %0d cell %0d,%0d",
						want.out_column, want.wall_distance, want.hit_kind, want.hit_side,
						want.hit_row, want.hit_col, got.out_column, got.wall_distance,
						got.hit_kind, got.hit_side, got.hit_row, got.hit_col);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ray_scoreboard sb = new();
	int words_sent = 0;
	int burst_left = 0;
	int stall_mode = 0;

	grid_ray_caster_dda_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#100ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver stall pattern: switch at random between no stall, light, heavy and periodic
	// stall so stalls land on every phase of the output.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if ($urandom_range(0, 299) == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: res_stall <= 1'b0;
				1: res_stall <= $urandom_range(0, 3) == 0;
				2: res_stall <= $urandom_range(0, 3) != 0;
				default: res_stall <= ~res_stall;
			endcase
		end
	end

	// Sample the result side at the falling edge: valid and stall are settled there and
	// decide the transfer at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res);
	end

	// Present one command word, with a random gap at the start of most bursts, and hold
	// it until the block takes it.
	task automatic send_word(cmd_t w);
		logic stalled;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				cmd_valid <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
		burst_left--;
		cmd_valid <= 1'b1;
		cmd <= w;
		do begin
			@(negedge clk);
			stalled = cmd_stall;
			@(posedge clk);
		end while (stalled);
		sb.note_word(w);
		words_sent++;
	endtask

	task automatic put_cell(int r, int c, logic [KIND_W-1:0] kind, logic [FRAC_W-1:0] open);
		cmd_t w;
		w = '0;
		w.func = FUNC_WRITE;
		w.cell_row = COORD_W'(r);
		w.cell_col = COORD_W'(c);
		w.cell_kind = kind;
		w.door_open = open;
		w.column = COL_W'($urandom);
		send_word(w);
	endtask

	task automatic cast(logic [COL_W-1:0] col);
		cmd_t w;
		w = cmd_t'($urandom);
		w.func = FUNC_CAST;
		w.column = col;
		send_word(w);
	endtask

	// Drop valid and let every expected hit arrive, then wait idle before the registers change.
	task automatic drain();
		cmd_valid <= 1'b0;
		burst_left = 0;
		while (sb.hits_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic set_camera(logic [21:0] pr, logic [21:0] pc, logic [15:0] dr,
		logic [15:0] dc, logic [15:0] plr, logic [15:0] plc, logic [12:0] sw);
		write_reg(CFG_POS_ROW, pr);
		write_reg(CFG_POS_COL, pc);
		write_reg(CFG_DIR_ROW, CFG_DATA_W'(dr));
		write_reg(CFG_DIR_COL, CFG_DATA_W'(dc));
		write_reg(CFG_PLANE_ROW, CFG_DATA_W'(plr));
		write_reg(CFG_PLANE_COL, CFG_DATA_W'(plc));
		write_reg(CFG_SCREEN_W, CFG_DATA_W'(sw));
	endtask

	function automatic logic [15:0] pick_dir();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'h8000;
			2: return 16'h7FFF;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic logic [FRAC_W-1:0] pick_open();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int vr, vc, sw, n_scene, n_cast;
		logic [1:0] kind;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset camera at cell 1,1 looking down the rows
		put_cell(6, 1, KIND_WALL, 16'h0);
		put_cell(3, 1, KIND_DOOR, 16'h8000);
		put_cell(4, 2, KIND_DOOR, 16'h0000);
		put_cell(2, 1, KIND_RESERVED, 16'h1234);
		put_cell(2, 0, KIND_DOOR, 16'hFFFF);
		put_cell(63, 63, KIND_WALL, 16'hFFFF);
		put_cell(0, 0, KIND_EMPTY, 16'h0);
		cast(0); cast(319); cast(320); cast(639); cast(640); cast(12'hFFF);
		drain();

		// extremes of the camera registers, narrow and wide screens
		set_camera(22'h0, 22'h3FFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 13'd0);
		cast(0); cast(1); cast(12'hFFF);
		drain();
		set_camera(22'h3FFFFF, 22'h0, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000, 13'd1);
		cast(0); cast(2047);
		drain();
		set_camera(22'h30000, 22'h38000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 13'd4096);
		cast(0); cast(4095);
		drain();

		// random scenes: walls and doors around the viewer, then casts across the screen
		while (words_sent < 900) begin
			vr = $urandom_range(0, 63);
			vc = $urandom_range(0, 63);
			sw = $urandom_range(0, 9) == 0 ? $urandom_range(0, 8191) : $urandom_range(2, 64);
			set_camera({vr[5:0], 16'($urandom)}, {vc[5:0], 16'($urandom)},
				pick_dir(), pick_dir(), pick_dir(), pick_dir(), SW_W'(sw));
			n_scene = $urandom_range(10, 40);
			for (int i = 0; i < n_scene; i++) begin
				kind = $urandom_range(0, 5) < 3 ? KIND_WALL : KIND_W'($urandom_range(0, 3));
				put_cell((vr + $urandom_range(0, 16) - 8) & 63,
					(vc + $urandom_range(0, 16) - 8) & 63, kind, pick_open());
			end
			n_cast = $urandom_range(20, 60);
			for (int i = 0; i < n_cast; i++) begin
				// mostly on-screen columns, a few writes mixed in as noise
				if ($urandom_range(0, 9) == 0)
					put_cell($urandom_range(0, 63), $urandom_range(0, 63),
						KIND_W'($urandom_range(0, 3)), FRAC_W'($urandom));
				else if ($urandom_range(0, 9) == 0)
					cast(COL_W'($urandom));
				else
					cast(COL_W'($urandom_range(0, (sw < 2 ? 2 : sw) - 1)));
			end
			drain();
		end

		repeat (200) @(posedge clk);
		sb.errors += sb.hits_due.size();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
